@@ hw/rtl/dsc_pkg.sv @@
// Shared types and constants for the delay-and-sum combiner.
// No dependencies; imported by dsc_delay_line, delay_and_sum_combiner and tb_top.
package dsc_pkg;

    // Number of channel ports and register groups on the block
    localparam int MAX_CH       = 4;
    // Field widths fixed by the register map
    localparam int DELAY_W      = 6;
    localparam int WEIGHT_W     = 16;
    // Q4.12 weights: twelve fraction bits, 4096 is unity
    localparam int FRAC_BITS    = 12;
    localparam logic [WEIGHT_W-1:0] UNITY_WEIGHT = 16'd4096;
    // APB register index width (eight registers, word spaced)
    localparam int REG_IDX_W    = 3;
    localparam int PADDR_W      = REG_IDX_W + 2;

    // Register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_DELAY_CH0  = 3'd0,
        REG_DELAY_CH1  = 3'd1,
        REG_DELAY_CH2  = 3'd2,
        REG_DELAY_CH3  = 3'd3,
        REG_WEIGHT_CH0 = 3'd4,
        REG_WEIGHT_CH1 = 3'd5,
        REG_WEIGHT_CH2 = 3'd6,
        REG_WEIGHT_CH3 = 3'd7
    } reg_idx_t;

    // Strobes from the top level to each delay line
    typedef struct packed {
        logic wr_en;   // request accepted: store the sample
        logic rd_en;   // first pipeline stage loads
    } dly_ctrl_t;

    // Source of the delayed tap
    typedef enum logic [1:0] {
        TAP_ZERO    = 2'd0,
        TAP_CURRENT = 2'd1,
        TAP_STORE   = 2'd2
    } tap_sel_t;

endpackage

@@ hw/rtl/dsc_delay_line.sv @@
// One channel's circular delay line: sample memory, read address and tap select.
// Depends on dsc_pkg.
module dsc_delay_line
    import dsc_pkg::*;
#(
    parameter int HISTORY_DEPTH = 64,
    parameter int SAMPLE_BITS   = 16,
    parameter int PTR_W         = 6
) (
    input  logic                          aclk,
    input  dly_ctrl_t                     ctrl,
    input  logic [PTR_W-1:0]              wr_addr,
    input  logic [PTR_W-1:0]              fill_cnt,
    input  logic [DELAY_W-1:0]            delay,
    input  logic signed [SAMPLE_BITS-1:0] wr_data,
    output logic signed [SAMPLE_BITS-1:0] tap
);

    localparam int CW = ((PTR_W > DELAY_W) ? PTR_W : DELAY_W) + 1;
    localparam logic [CW-1:0] LAST  = CW'(HISTORY_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH = CW'(HISTORY_DEPTH);

    logic signed [SAMPLE_BITS-1:0] mem [HISTORY_DEPTH];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic signed [SAMPLE_BITS-1:0] cur_data_reg;
    tap_sel_t                      sel_reg;
    tap_sel_t                      sel_next;
    logic [CW-1:0]                 d_ext;
    logic [CW-1:0]                 d_clamp;
    logic [CW-1:0]                 wp_ext;
    logic [CW-1:0]                 rp_full;
    logic [PTR_W-1:0]              rd_addr;

    // Clamp the delay to the store and step back from the write slot
    always_comb begin
        d_ext   = CW'(delay);
        d_clamp = (d_ext > LAST) ? LAST : d_ext;
        wp_ext  = CW'(wr_addr);
        if (wp_ext >= d_clamp) begin
            rp_full = wp_ext - d_clamp;
        end else begin
            rp_full = wp_ext + DEPTH - d_clamp;
        end
        rd_addr = rp_full[PTR_W-1:0];
        // Zero delay takes the current sample; a slot not yet written reads as zero
        priority if (d_clamp == '0) begin
            sel_next = TAP_CURRENT;
        end else if (d_clamp > CW'(fill_cnt)) begin
            sel_next = TAP_ZERO;
        end else begin
            sel_next = TAP_STORE;
        end
    end

    // Store the incoming sample
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read alongside the bypass sample and select
    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            cur_data_reg <= wr_data;
            sel_reg      <= sel_next;
        end
    end

    always_comb begin
        unique case (sel_reg)
            TAP_CURRENT: tap = cur_data_reg;
            TAP_STORE:   tap = rd_data_reg;
            default:     tap = '0;
        endcase
    end

endmodule

@@ hw/rtl/delay_and_sum_combiner.sv @@
// Top level of the delay-and-sum combiner: APB registers, write pointer,
// pipeline control, weighting and saturation. Depends on dsc_pkg, dsc_delay_line.
//
// The block takes one request per cycle while s_ready is high. Stage one
// reads each channel's delay line (one write and one registered read port
// per channel memory), stage two multiplies by the Q4.12 weights, stage
// three sums, floors twelve fraction bits and saturates.
// Each stage holds only while its successor is full and stalled, so requests
// keep flowing while a result waits. The delay lines are not cleared after
// reset: a fill count of accepted requests marks slots not yet written, which
// read as zero, so the block is ready as soon as reset is released.
// Registers and delays may be changed only while the block is idle.
module delay_and_sum_combiner
    import dsc_pkg::*;
#(
    parameter int CHANNELS      = 4,
    parameter int HISTORY_DEPTH = 64,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [PADDR_W-1:0]            paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // Sample request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_ch0,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_ch1,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_ch2,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_ch3,
    // Result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_summed_sample
);

    localparam int PTR_W  = $clog2(HISTORY_DEPTH);
    localparam int PROD_W = SAMPLE_BITS + WEIGHT_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);
    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO =
        {{(SUM_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    logic [DELAY_W-1:0]            delay_reg  [MAX_CH];
    logic [WEIGHT_W-1:0]           weight_reg [MAX_CH];
    logic [PTR_W-1:0]              wp_reg;
    logic [PTR_W-1:0]              wp_next;
    logic [PTR_W-1:0]              fill_reg;
    logic [PTR_W-1:0]              fill_next;
    logic                          v1_reg;
    logic                          v2_reg;
    logic                          out_valid_reg;
    logic                          en1;
    logic                          en2;
    logic                          en3;
    logic                          accept;
    logic                          cfg_wr;
    reg_idx_t                      cfg_idx;
    dly_ctrl_t                     dly_ctrl;
    logic signed [SAMPLE_BITS-1:0] samples [MAX_CH];
    logic signed [SAMPLE_BITS-1:0] taps    [CHANNELS];
    logic signed [PROD_W-1:0]      prod_reg  [CHANNELS];
    logic signed [PROD_W-1:0]      prod_next [CHANNELS];
    logic signed [SUM_W-1:0]       acc;
    logic signed [SUM_W-1:0]       shifted;
    logic signed [SAMPLE_BITS-1:0] result_reg;
    logic signed [SAMPLE_BITS-1:0] result_next;

    assign samples[0] = s_sample_ch0;
    assign samples[1] = s_sample_ch1;
    assign samples[2] = s_sample_ch2;
    assign samples[3] = s_sample_ch3;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

    // Write the addressed register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_CH; i++) begin
                delay_reg[i]  <= '0;
                weight_reg[i] <= UNITY_WEIGHT;
            end
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_DELAY_CH0:  delay_reg[0]  <= pwdata[DELAY_W-1:0];
                REG_DELAY_CH1:  delay_reg[1]  <= pwdata[DELAY_W-1:0];
                REG_DELAY_CH2:  delay_reg[2]  <= pwdata[DELAY_W-1:0];
                REG_DELAY_CH3:  delay_reg[3]  <= pwdata[DELAY_W-1:0];
                REG_WEIGHT_CH0: weight_reg[0] <= pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_CH1: weight_reg[1] <= pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_CH2: weight_reg[2] <= pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_CH3: weight_reg[3] <= pwdata[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (cfg_idx)
            REG_DELAY_CH0:  prdata = 32'(delay_reg[0]);
            REG_DELAY_CH1:  prdata = 32'(delay_reg[1]);
            REG_DELAY_CH2:  prdata = 32'(delay_reg[2]);
            REG_DELAY_CH3:  prdata = 32'(delay_reg[3]);
            REG_WEIGHT_CH0: prdata = 32'(weight_reg[0]);
            REG_WEIGHT_CH1: prdata = 32'(weight_reg[1]);
            REG_WEIGHT_CH2: prdata = 32'(weight_reg[2]);
            REG_WEIGHT_CH3: prdata = 32'(weight_reg[3]);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: each stage advances when its successor has room
    // ------------------------------------------------------------------
    assign en3     = !out_valid_reg || m_ready;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;
    assign accept  = s_valid && s_ready;

    assign dly_ctrl.wr_en = accept;
    assign dly_ctrl.rd_en = en1;

    // Advance the write slot and count filled slots up to one less than the store size
    always_comb begin
        wp_next   = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
        fill_next = (fill_reg == PTR_LAST) ? fill_reg : fill_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg        <= '0;
            fill_reg      <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                wp_reg   <= wp_next;
                fill_reg <= fill_next;
            end
            if (en1) begin
                v1_reg <= s_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                out_valid_reg <= v2_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage one: per-channel delay lines
    // ------------------------------------------------------------------
    for (genvar g = 0; g < CHANNELS; g++) begin : g_ch
        dsc_delay_line #(
            .HISTORY_DEPTH (HISTORY_DEPTH),
            .SAMPLE_BITS   (SAMPLE_BITS),
            .PTR_W         (PTR_W)
        ) u_line (
            .aclk     (aclk),
            .ctrl     (dly_ctrl),
            .wr_addr  (wp_reg),
            .fill_cnt (fill_reg),
            .delay    (delay_reg[g]),
            .wr_data  (samples[g]),
            .tap      (taps[g])
        );
    end

    // ------------------------------------------------------------------
    // Stage two: apply the unsigned Q4.12 weights
    // ------------------------------------------------------------------
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            prod_next[c] = PROD_W'(taps[c])
                         * PROD_W'($signed({1'b0, weight_reg[c]}));
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            for (int c = 0; c < CHANNELS; c++) begin
                prod_reg[c] <= prod_next[c];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage three: sum, floor the fraction bits, saturate
    // ------------------------------------------------------------------
    always_comb begin
        acc = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            acc = acc + SUM_W'(prod_reg[c]);
        end
        shifted = acc >>> FRAC_BITS;
        priority if (shifted > SAT_HI) begin
            result_next = SAT_HI[SAMPLE_BITS-1:0];
        end else if (shifted < SAT_LO) begin
            result_next = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            result_next = shifted[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            result_reg <= result_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_summed_sample = result_reg;

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the delay-and-sum combiner: random and directed
// sample frames, APB register settings, a bit-true predictor of the weighted sum.
// Depends on dsc_pkg and delay_and_sum_combiner.
module tb_top
    import dsc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS      = 4;
    localparam int HIST_DEPTH    = 64;
    localparam int SAMPLE_BITS   = 16;
    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_FRAMES  = 137;
    localparam logic signed [47:0] SUM_MAX = 48'sd32767;
    localparam logic signed [47:0] SUM_MIN = -48'sd32768;

    typedef logic [MAX_CH-1:0][SAMPLE_BITS-1:0] samples_t;

    typedef struct packed {
        logic     drain_first;  // hold the request until every result is back
        samples_t smp;
    } frame_t;

    logic                          aclk    = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [PADDR_W-1:0]            paddr   = '0;
    logic [31:0]                   pwdata  = '0;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_sample_ch0 = '0;
    logic signed [SAMPLE_BITS-1:0] s_sample_ch1 = '0;
    logic signed [SAMPLE_BITS-1:0] s_sample_ch2 = '0;
    logic signed [SAMPLE_BITS-1:0] s_sample_ch3 = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] m_summed_sample;

    frame_t                        pending_frames[$];
    logic signed [SAMPLE_BITS-1:0] expected_sums[$];
    int frames_sent     = 0;
    int frames_accepted = 0;
    int error_count     = 0;
    int cycle_count     = 0;
    int idle_pct        = 26;

    // Predictor state: per-channel history, write slot and register copies
    logic [SAMPLE_BITS-1:0] history [MAX_CH][HIST_DEPTH];
    int                     wr_pos;
    logic [DELAY_W-1:0]     delay_cfg  [MAX_CH];
    logic [WEIGHT_W-1:0]    weight_cfg [MAX_CH];

    delay_and_sum_combiner #(
        .CHANNELS      (CHANNELS),
        .HISTORY_DEPTH (HIST_DEPTH),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample_ch0    (s_sample_ch0),
        .s_sample_ch1    (s_sample_ch1),
        .s_sample_ch2    (s_sample_ch2),
        .s_sample_ch3    (s_sample_ch3),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_summed_sample (m_summed_sample)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Store the new frame, read each delayed tap, weight, sum, floor, saturate
    function automatic logic signed [SAMPLE_BITS-1:0] predict_beam_sum(input samples_t smp);
        logic signed [47:0] acc;
        logic signed [47:0] floored;
        int ch;
        int d;
        int rp;
        acc = '0;
        for (ch = 0; ch < CHANNELS; ch++) begin
            d = int'(delay_cfg[ch]);
            if (d > HIST_DEPTH - 1) d = HIST_DEPTH - 1;
            history[ch][wr_pos] = smp[ch];
            rp = (wr_pos + HIST_DEPTH - d) % HIST_DEPTH;
            acc = acc + $signed(history[ch][rp]) * $signed({1'b0, weight_cfg[ch]});
        end
        wr_pos = (wr_pos + 1) % HIST_DEPTH;
        // arithmetic shift floors toward minus infinity
        floored = acc >>> FRAC_BITS;
        if (floored > SUM_MAX) floored = SUM_MAX;
        if (floored < SUM_MIN) floored = SUM_MIN;
        return floored[SAMPLE_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string what, input int expected, input int got);
        $display("[%0t] mismatch: %s expected %0d got %0d", $realtime, what, expected, got);
        error_count++;
    endtask

    // APB write: setup cycle, access cycle, register taken when pready is high
    task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (idx < REG_WEIGHT_CH0) delay_cfg[int'(idx)] = value[DELAY_W-1:0];
        else weight_cfg[int'(idx) - int'(REG_WEIGHT_CH0)] = value[WEIGHT_W-1:0];
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write all eight registers, with junk in the unused upper bits
    task automatic apply_setting(input logic [MAX_CH-1:0][DELAY_W-1:0] dl,
                                 input logic [MAX_CH-1:0][WEIGHT_W-1:0] wt);
        logic [31:0] word;
        int ch;
        for (ch = 0; ch < MAX_CH; ch++) begin
            word = $urandom();
            word[DELAY_W-1:0] = dl[ch];
            write_register(reg_idx_t'(int'(REG_DELAY_CH0) + ch), word);
        end
        for (ch = 0; ch < MAX_CH; ch++) begin
            word = $urandom();
            word[WEIGHT_W-1:0] = wt[ch];
            write_register(reg_idx_t'(int'(REG_WEIGHT_CH0) + ch), word);
        end
    endtask

    task automatic queue_frame(input int c0, input int c1, input int c2, input int c3,
                               input bit drain);
        frame_t f;
        f.drain_first = drain;
        f.smp[0] = c0[SAMPLE_BITS-1:0];
        f.smp[1] = c1[SAMPLE_BITS-1:0];
        f.smp[2] = c2[SAMPLE_BITS-1:0];
        f.smp[3] = c3[SAMPLE_BITS-1:0];
        pending_frames.push_back(f);
    endtask

    // Mostly full-scale noise, some quiet samples and some rail values
    function automatic int random_sample(input int mode);
        unique case (mode)
            6, 7: return $urandom_range(600) - 300;
            8: begin
                unique case ($urandom_range(2))
                    0: return 32767;
                    1: return -32768;
                    default: return 0;
                endcase
            end
            default: return $signed(16'($urandom()));
        endcase
    endfunction

    task automatic wait_drained;
        while (pending_frames.size() != 0 || frames_sent != frames_accepted ||
               expected_sums.size() != 0)
            @(posedge aclk);
    endtask

    // Driver: present the next request, hold it until accepted
    always @(negedge aclk) begin
        frame_t f;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (frames_sent == frames_accepted) begin
            if (pending_frames.size() == 0 || $urandom_range(99) < idle_pct ||
                (pending_frames[0].drain_first && expected_sums.size() != 0)) begin
                s_valid <= 1'b0;
            end else begin
                f = pending_frames.pop_front();
                s_sample_ch0 <= f.smp[0];
                s_sample_ch1 <= f.smp[1];
                s_sample_ch2 <= f.smp[2];
                s_sample_ch3 <= f.smp[3];
                s_valid      <= 1'b1;
                frames_sent++;
            end
        end
    end

    // Receiver back-pressure
    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= idle_pct);
    end

    // Monitor: predict on each accepted request, check each accepted result
    always @(posedge aclk) begin
        logic signed [SAMPLE_BITS-1:0] want;
        cycle_count++;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_sums.push_back(predict_beam_sum(
                    {s_sample_ch3, s_sample_ch2, s_sample_ch1, s_sample_ch0}));
                frames_accepted++;
            end
            if (m_valid && m_ready) begin
                if (expected_sums.size() == 0) begin
                    report_mismatch("result with none pending", 0, int'(m_summed_sample));
                end else begin
                    want = expected_sums.pop_front();
                    if (m_summed_sample !== want)
                        report_mismatch("summed_sample", int'(want), int'(m_summed_sample));
                end
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL delay_and_sum_combiner");
        $finish;
    end

    initial begin
        logic [MAX_CH-1:0][DELAY_W-1:0]  dl;
        logic [MAX_CH-1:0][WEIGHT_W-1:0] wt;
        int ph;
        int n;
        int ch;
        int mode;

        // Predictor matches the block's reset state
        for (ch = 0; ch < MAX_CH; ch++) begin
            delay_cfg[ch]  = '0;
            weight_cfg[ch] = UNITY_WEIGHT;
            for (n = 0; n < HIST_DEPTH; n++) history[ch][n] = '0;
        end
        wr_pos = 0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: zero delay uses the current sample, rails saturate
        queue_frame(32767, 32767, 32767, 32767, 1'b0);
        queue_frame(-32768, -32768, -32768, -32768, 1'b0);
        queue_frame(0, 0, 0, 0, 1'b0);
        queue_frame(1, -1, 2, -2, 1'b0);
        queue_frame(32767, -32768, 0, 0, 1'b0);
        queue_frame(12345, -100, 7, 0, 1'b0);
        wait_drained();

        // Mixed delays and weights: early taps read zero, tiny weights floor
        dl = {6'd0, 6'd63, 6'd2, 6'd1};
        wt = {16'd1, 16'd2048, 16'hFFFF, 16'd1};
        apply_setting(dl, wt);
        queue_frame(0, 0, 0, -1, 1'b0);
        queue_frame(0, 0, 0, 1, 1'b0);
        queue_frame(-1, 0, 0, -4097, 1'b0);
        queue_frame(-32768, 32767, -32768, 32767, 1'b0);
        queue_frame(32767, -32768, 32767, -32768, 1'b0);
        queue_frame(0, 32767, 0, 0, 1'b0);
        queue_frame(0, -32768, 0, 0, 1'b0);
        queue_frame(-4096, 1, -1, 4095, 1'b0);
        queue_frame(0, 0, 0, 0, 1'b0);
        queue_frame(100, -100, 32767, -1, 1'b0);
        queue_frame(-1, -1, -1, -1, 1'b0);
        wait_drained();

        // Random phases, each under a fresh register setting
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            for (ch = 0; ch < MAX_CH; ch++) begin
                unique case (ph)
                    0: begin
                        dl[ch] = '1;
                        wt[ch] = '1;
                    end
                    1: begin
                        dl[ch] = '0;
                        wt[ch] = '0;
                    end
                    2: begin
                        dl[ch] = DELAY_W'($urandom_range(HIST_DEPTH - 1));
                        wt[ch] = UNITY_WEIGHT;
                    end
                    default: begin
                        dl[ch] = DELAY_W'($urandom_range(HIST_DEPTH - 1));
                        wt[ch] = WEIGHT_W'(($urandom_range(2) == 0) ? $urandom_range(65535)
                                                                   : $urandom_range(4096));
                    end
                endcase
            end
            apply_setting(dl, wt);
            // one phase runs with no idling on either side
            idle_pct = (ph == 4) ? 0 : 26;
            for (n = 0; n < PHASE_FRAMES; n++) begin
                mode = $urandom_range(9);
                if (mode == 9) begin
                    ch = random_sample(0);
                    queue_frame(ch, ch, ch, ch, $urandom_range(199) == 0);
                end else begin
                    queue_frame(random_sample(mode), random_sample(mode),
                                random_sample(mode), random_sample(mode),
                                $urandom_range(199) == 0);
                end
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("PASS delay_and_sum_combiner");
        else
            $display("FAIL delay_and_sum_combiner");
        $finish;
    end

endmodule
